// ===== design/lfe_pkg.sv =====
// Shared types and constants of the LED fade envelope core.
`timescale 1ns / 1ps
`default_nettype none
package lfe_pkg;

	localparam int TIME_W = 32;   // elapsed and latency time in microseconds
	localparam int PER_W  = 26;   // repeat period in microseconds
	localparam int DUR_W  = 22;   // one envelope segment in microseconds
	localparam int NUM_W  = 30;   // 255 times a segment offset
	localparam int LVL_W  = 8;
	localparam int CH_W   = 8;

	localparam int UNIT_US    = 10000;
	localparam int MS_US      = 1000;
	localparam int FULL_LEVEL = 255;

	// floor(x / 255) for x below 65536 is (x * RECIP_255) >> RECIP_SHIFT
	localparam int RECIP_255   = 32897;
	localparam int RECIP_SHIFT = 23;

	// Remainder unit: quotient of elapsed time by the period fits 24 bits
	localparam int MOD_STEPS     = 24;
	localparam int MOD_PER_STAGE = 2;
	localparam int MOD_STAGES    = MOD_STEPS / MOD_PER_STAGE;

	// Level divider: 8 quotient bits, two per stage
	localparam int DIV_STEPS     = 8;
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;

	typedef enum logic [1:0] {
		PH_FADE_IN  = 2'd0,
		PH_FULL     = 2'd1,
		PH_FADE_OUT = 2'd2,
		PH_DARK     = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		REG_MODE     = 3'd0,
		REG_REPEAT   = 3'd1,
		REG_PERIOD   = 3'd2,
		REG_LATENCY  = 3'd3,
		REG_FADEIN   = 3'd4,
		REG_ON       = 3'd5,
		REG_FADEOUT  = 3'd6,
		REG_COLOR    = 3'd7
	} cfg_idx_t;

endpackage
`default_nettype wire

// ===== design/lfe_mod_pipe.sv =====
// Pipelined restoring remainder of elapsed time by the repeat period.
`timescale 1ns / 1ps
`default_nettype none
module lfe_mod_pipe (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_vld,
	input  wire logic [lfe_pkg::TIME_W-1:0] in_d,
	input  wire logic                      in_dark,
	input  wire logic                      wrap,
	input  wire logic [lfe_pkg::PER_W-1:0]  p_us,
	output logic                           out_vld,
	output logic [lfe_pkg::TIME_W-1:0]      out_d,
	output logic                           out_dark
);
	import lfe_pkg::*;

	localparam int SH_W = PER_W + MOD_STEPS + 6;

	logic [TIME_W-1:0] rem_s  [MOD_STAGES+1];
	logic              vld_s  [MOD_STAGES+1];
	logic              dark_s [MOD_STAGES+1];

	assign rem_s[0]  = in_d;
	assign vld_s[0]  = in_vld;
	assign dark_s[0] = in_dark;

	genvar g;
	generate
		for (g = 0; g < MOD_STAGES; g++) begin : g_stage
			logic [TIME_W-1:0] nxt;

			// two compare-subtract steps when wrap is set, highest quotient bit first
			always_comb begin
				logic [SH_W-1:0] sh;
				nxt = rem_s[g];
				for (int k = 0; k < MOD_PER_STAGE; k++) begin
					sh = {{(SH_W-PER_W){1'b0}}, p_us} << (MOD_STEPS - 1 - (g * MOD_PER_STAGE + k));
					if (wrap && ({{(SH_W-TIME_W){1'b0}}, nxt} >= sh))
						nxt = nxt - sh[TIME_W-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g+1] <= 1'b0;
				end else if (en) begin
					vld_s[g+1] <= vld_s[g];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g+1]  <= nxt;
					dark_s[g+1] <= dark_s[g];
				end
			end
		end
	endgenerate

	assign out_vld  = vld_s[MOD_STAGES];
	assign out_d    = rem_s[MOD_STAGES];
	assign out_dark = dark_s[MOD_STAGES];

endmodule
`default_nettype wire

// ===== design/lfe_div_pipe.sv =====
// Pipelined restoring divider that yields the 8-bit brightness level.
`timescale 1ns / 1ps
`default_nettype none
module lfe_div_pipe (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_vld,
	input  wire logic [lfe_pkg::NUM_W-1:0]  in_num,
	input  wire logic [lfe_pkg::DUR_W-1:0]  in_dvs,
	input  wire logic                      in_full,
	input  wire lfe_pkg::phase_t           in_ph,
	output logic                           out_vld,
	output logic [lfe_pkg::LVL_W-1:0]       out_level,
	output lfe_pkg::phase_t                out_ph
);
	import lfe_pkg::*;

	logic [NUM_W-1:0] rem_s  [DIV_STAGES+1];
	logic [LVL_W-1:0] q_s    [DIV_STAGES+1];
	logic [DUR_W-1:0] dvs_s  [DIV_STAGES+1];
	logic             full_s [DIV_STAGES+1];
	phase_t           ph_s   [DIV_STAGES+1];
	logic             vld_s  [DIV_STAGES+1];

	assign rem_s[0]  = in_num;
	assign q_s[0]    = '0;
	assign dvs_s[0]  = in_dvs;
	assign full_s[0] = in_full;
	assign ph_s[0]   = in_ph;
	assign vld_s[0]  = in_vld;

	genvar g;
	generate
		for (g = 0; g < DIV_STAGES; g++) begin : g_stage
			logic [NUM_W-1:0] rnxt;
			logic [LVL_W-1:0] qnxt;

			always_comb begin
				logic [NUM_W-1:0] sh;
				rnxt = rem_s[g];
				qnxt = q_s[g];
				for (int k = 0; k < DIV_PER_STAGE; k++) begin
					sh = {{(NUM_W-DUR_W){1'b0}}, dvs_s[g]} << (DIV_STEPS - 1 - (g * DIV_PER_STAGE + k));
					if (rnxt >= sh) begin
						rnxt = rnxt - sh;
						qnxt[DIV_STEPS - 1 - (g * DIV_PER_STAGE + k)] = 1'b1;
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g+1] <= 1'b0;
				end else if (en) begin
					vld_s[g+1] <= vld_s[g];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g+1]  <= rnxt;
					q_s[g+1]    <= qnxt;
					dvs_s[g+1]  <= dvs_s[g];
					full_s[g+1] <= full_s[g];
					ph_s[g+1]   <= ph_s[g];
				end
			end
		end
	endgenerate

	assign out_vld   = vld_s[DIV_STAGES];
	assign out_level = full_s[DIV_STAGES] ? LVL_W'(FULL_LEVEL) : q_s[DIV_STAGES];
	assign out_ph    = ph_s[DIV_STAGES];

endmodule
`default_nettype wire

// ===== design/lfe_scale.sv =====
// Two-stage color scaling by level/255; the second stage is the output register.
`timescale 1ns / 1ps
`default_nettype none
module lfe_scale (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_vld,
	input  wire logic [lfe_pkg::LVL_W-1:0]    in_level,
	input  wire lfe_pkg::phase_t             in_ph,
	input  wire logic [3*lfe_pkg::CH_W-1:0]   color,
	output logic                             out_vld,
	output logic [lfe_pkg::CH_W-1:0]          out_red,
	output logic [lfe_pkg::CH_W-1:0]          out_green,
	output logic [lfe_pkg::CH_W-1:0]          out_blue,
	output lfe_pkg::phase_t                  out_ph
);
	import lfe_pkg::*;

	localparam int PW = LVL_W + CH_W;
	localparam int MW = 2 * PW;

	logic [PW-1:0] prod_s1 [3];
	phase_t        ph_s1;
	logic          vld_s1;
	logic [CH_W-1:0] quo [3];

	// products level * channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++)
				prod_s1[c] <= PW'(in_level) * PW'(color[(2-c)*CH_W +: CH_W]);
			ph_s1 <= in_ph;
		end
	end

	// divide by 255 through a reciprocal multiply; a dark phase gives zero
	always_comb begin
		logic [MW-1:0] m;
		for (int c = 0; c < 3; c++) begin
			m = MW'(prod_s1[c]) * MW'(RECIP_255);
			quo[c] = (ph_s1 == PH_DARK) ? '0 : m[RECIP_SHIFT +: CH_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_red   <= quo[0];
			out_green <= quo[1];
			out_blue  <= quo[2];
			out_ph    <= ph_s1;
		end
	end

endmodule
`default_nettype wire

// ===== design/led_fade_envelope_core.sv =====
// Pipeline stages from an accepted item to its result: 1 subtract, 12 remainder,
// 1 envelope classify, 4 level divide, 2 color scale.
// Throughput: one item per cycle; the whole pipeline advances when the output
// register is empty or taken, so a held result stalls every stage.
// Reset: arst_n clears all valid bits and every configuration register to zero.
// Scaled durations are formed at register write time.
`timescale 1ns / 1ps
`default_nettype none
module led_fade_envelope_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] elapsed_us
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [7:0] red_out, [15:8] green_out,
	                                    // [23:16] blue_out, [25:24] phase, rest zero
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import lfe_pkg::*;

	logic               en;
	logic               mode_q, rep_q;
	logic [PER_W-1:0]   p_us_q;
	logic [TIME_W-1:0]  lat_q;
	logic [DUR_W-1:0]   fi_q, on_q, fo_q;
	logic [3*CH_W-1:0]  color_q;
	logic               wrap;

	// configuration registers, durations kept in microseconds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			rep_q   <= 1'b0;
			p_us_q  <= '0;
			lat_q   <= '0;
			fi_q    <= '0;
			on_q    <= '0;
			fo_q    <= '0;
			color_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_MODE:    mode_q  <= cfg_data[0];
				REG_REPEAT:  rep_q   <= cfg_data[0];
				REG_PERIOD:  p_us_q  <= PER_W'(cfg_data[15:0]) * PER_W'(MS_US);
				REG_LATENCY: lat_q   <= cfg_data;
				REG_FADEIN:  fi_q    <= DUR_W'(cfg_data[7:0]) * DUR_W'(UNIT_US);
				REG_ON:      on_q    <= DUR_W'(cfg_data[7:0]) * DUR_W'(UNIT_US);
				REG_FADEOUT: fo_q    <= DUR_W'(cfg_data[7:0]) * DUR_W'(UNIT_US);
				REG_COLOR:   color_q <= cfg_data[3*CH_W-1:0];
				default:     ;
			endcase
		end
	end

	assign wrap     = rep_q && (p_us_q != '0);
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: subtract latency
	logic              vld_s1, dark_s1;
	logic [TIME_W-1:0] d_s1;
	logic [TIME_W:0]   diff;

	assign diff = {1'b0, s_tdata} - {1'b0, lat_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= diff[TIME_W-1:0];
			dark_s1 <= diff[TIME_W];
		end
	end

	// stages 2..13: wrap into the repeat period
	logic              mod_vld, mod_dark;
	logic [TIME_W-1:0] mod_d;

	lfe_mod_pipe u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.in_d     (d_s1),
		.in_dark  (dark_s1),
		.wrap     (wrap),
		.p_us     (p_us_q),
		.out_vld  (mod_vld),
		.out_d    (mod_d),
		.out_dark (mod_dark)
	);

	// stage 14: envelope segment and divider operands
	logic [DUR_W:0]   fion;
	logic [DUR_W+1:0] fionfo;
	logic [DUR_W-1:0] x_c, dvs_c;
	logic             full_c;
	phase_t           ph_c;

	assign fion   = {1'b0, fi_q} + {1'b0, on_q};
	assign fionfo = {1'b0, fion} + {2'b0, fo_q};

	always_comb begin
		logic [DUR_W+1:0] rest;
		rest   = '0;
		x_c    = '0;
		dvs_c  = fi_q;
		full_c = 1'b0;
		ph_c   = PH_DARK;
		if (mod_dark) begin
			ph_c = PH_DARK;
		end else if ((fi_q != '0) && (mod_d < TIME_W'(fi_q))) begin
			ph_c = PH_FADE_IN;
			x_c  = mod_d[DUR_W-1:0];
		end else if (mode_q || (mod_d < TIME_W'(fion))) begin
			ph_c   = PH_FULL;
			full_c = 1'b1;
		end else if ((fo_q != '0) && (mod_d < TIME_W'(fionfo))) begin
			ph_c  = PH_FADE_OUT;
			rest  = fionfo - mod_d[DUR_W+1:0];
			x_c   = rest[DUR_W-1:0];
			dvs_c = fo_q;
		end
	end

	logic             vld_s14, full_s14;
	logic [NUM_W-1:0] num_s14;
	logic [DUR_W-1:0] dvs_s14;
	phase_t           ph_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s14 <= 1'b0;
		end else if (en) begin
			vld_s14 <= mod_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s14  <= (NUM_W'(x_c) << LVL_W) - NUM_W'(x_c);
			dvs_s14  <= dvs_c;
			full_s14 <= full_c;
			ph_s14   <= ph_c;
		end
	end

	// stages 15..18: brightness level
	logic             div_vld;
	logic [LVL_W-1:0] div_level;
	phase_t           div_ph;

	lfe_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (vld_s14),
		.in_num    (num_s14),
		.in_dvs    (dvs_s14),
		.in_full   (full_s14),
		.in_ph     (ph_s14),
		.out_vld   (div_vld),
		.out_level (div_level),
		.out_ph    (div_ph)
	);

	// stages 19..20: color scaling and output register
	logic [CH_W-1:0] red_out, green_out, blue_out;
	phase_t          phase;

	lfe_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (div_vld),
		.in_level  (div_level),
		.in_ph     (div_ph),
		.color     (color_q),
		.out_vld   (m_tvalid),
		.out_red   (red_out),
		.out_green (green_out),
		.out_blue  (blue_out),
		.out_ph    (phase)
	);

	assign m_tdata = {6'd0, phase, blue_out, green_out, red_out};

	// a dark result carries no color
	a_dark_black: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (phase == PH_DARK)) |-> (m_tdata[23:0] == 24'd0))
		else $error("dark result with nonzero color");

	// an accepted item occupies the first stage on the next edge
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s1)
		else $error("accepted item lost at pipeline entry");

	// stalled pipeline keeps the occupancy of the first stage and of stage 14
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s1) && $stable(vld_s14))
		else $error("pipeline moved while stalled");

endmodule
`default_nettype wire
